/* rtl/core/bkem_pkg.sv */
// Shared types, constants and helpers for the bitap k-error matcher.
package bkem_pkg;

  // Sizing of the matcher.
  localparam int PATTERN_BITS  = 64;
  localparam int MAX_ERRORS    = 8;
  localparam int POSITION_BITS = 32;

  localparam int LEVELS   = MAX_ERRORS + 1;
  localparam int LEVEL_W  = $clog2(LEVELS);
  localparam int BIT_IDX_W = $clog2(PATTERN_BITS);

  // Field widths fixed by the item formats.
  localparam int CODE_W       = 8;
  localparam int TABLE_DEPTH  = 256;
  localparam int ERR_CFG_W    = 4;
  localparam int LEN_CFG_W    = 7;
  localparam int CFG_DATA_W   = 7;
  localparam int MATCH_END_W  = 32;

  typedef logic [PATTERN_BITS-1:0]  pat_vec_t;
  typedef logic [POSITION_BITS-1:0] position_t;
  typedef logic [LEVEL_W-1:0]       level_t;

  localparam pat_vec_t  PAT_ONES = ~pat_vec_t'(0);
  localparam position_t POS_MAX  = ~position_t'(0);

  // Input actions.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_SCAN = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_ERROR_COUNT    = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_index_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } bkem_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load_wr;     // write one character mask entry
    logic   scan_start;  // read the entry, restart if asked, advance position
    logic   step_en;     // update one error level
    level_t step_lv;     // level being updated
    logic   out_load;    // capture a match into the output register
  } bkem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_level;    // the level in work is the highest active one
    logic hit;           // the highest active level shows a full match
    logic out_busy;      // output register holds an item that is not taken
  } bkem_status_t;

  // Restart value of one level mask: all ones shifted left by the level.
  function automatic pat_vec_t level_init(input int lv);
    return PAT_ONES << lv;
  endfunction

endpackage

/* rtl/core/bkem_if.sv */
// Channel interfaces of the bitap k-error matcher: text input, match output, config.
interface bkem_in_if import bkem_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic                    new_text;
  logic [CODE_W-1:0]       char_code;
  logic [PATTERN_BITS-1:0] mask_value;

  modport source (output valid, action, new_text, char_code, mask_value, input ready);
  modport sink   (input valid, action, new_text, char_code, mask_value, output ready);
endinterface

interface bkem_out_if import bkem_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MATCH_END_W-1:0] match_end;

  modport source (output valid, match_end, input ready);
  modport sink   (input valid, match_end, output ready);
endinterface

interface bkem_cfg_if import bkem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/bkem_ctrl.sv */
// Controller state machine of the bitap k-error matcher.
module bkem_ctrl import bkem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_action,
  output logic         in_ready,
  input  bkem_status_t status,
  output bkem_cmd_t    cmd
);

  bkem_state_t state, state_next;
  level_t      lv, lv_next;

  // State and level counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lv    <= '0;
    end else begin
      state <= state_next;
      lv    <= lv_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    lv_next        = lv;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.step_lv    = lv;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action_t'(in_action) == ACT_SCAN) begin
            cmd.scan_start = 1'b1;
            lv_next        = '0;
            state_next     = ST_STEP;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_STEP: begin
        cmd.step_en = 1'b1;
        if (status.last_level) begin
          state_next = ST_FINISH;
        end else begin
          lv_next = lv + level_t'(1);
        end
      end
      ST_FINISH: begin
        // A match waits here while the previous result is still not taken.
        if (!status.hit) begin
          state_next = ST_IDLE;
        end else if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bkem_dp.sv */
// Datapath of the bitap k-error matcher: mask table, level masks, position, output.
module bkem_dp import bkem_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_new_text,
  input  logic [CODE_W-1:0]       in_char_code,
  input  logic [PATTERN_BITS-1:0] in_mask_value,
  input  logic                    cfg_valid,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    cfg_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MATCH_END_W-1:0]  match_end,
  input  bkem_cmd_t               cmd,
  output bkem_status_t            status
);

  pat_vec_t      char_mask_table [TABLE_DEPTH];
  pat_vec_t      table_rdata;
  pat_vec_t      level_masks [LEVELS];
  pat_vec_t      prev_low, cur_low;
  position_t     text_position, pos_base;
  logic [ERR_CFG_W-1:0] error_count;
  logic [LEN_CFG_W-1:0] pattern_length;
  level_t        errs;
  logic [BIT_IDX_W-1:0] end_idx;
  pat_vec_t      cmask, prev_this, level_next;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_count    <= '0;
      pattern_length <= LEN_CFG_W'(PATTERN_BITS);
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        REG_ERROR_COUNT:    error_count    <= cfg_data[ERR_CFG_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Character mask table, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      char_mask_table[in_char_code] <= in_mask_value;
    end
    if (cmd.scan_start) begin
      table_rdata <= char_mask_table[in_char_code];
    end
  end

  // Active level count and match bit, both saturated.
  always_comb begin
    if (int'(error_count) > MAX_ERRORS) begin
      errs = level_t'(MAX_ERRORS);
    end else begin
      errs = level_t'(error_count);
    end
    if (int'(pattern_length) > PATTERN_BITS) begin
      end_idx = BIT_IDX_W'(PATTERN_BITS - 1);
    end else begin
      end_idx = BIT_IDX_W'(pattern_length - LEN_CFG_W'(1));
    end
  end

  // One level update of the shared step unit.
  always_comb begin
    cmask     = ~table_rdata;
    prev_this = level_masks[cmd.step_lv];
    if (cmd.step_lv == '0) begin
      level_next = (prev_this << 1) | cmask;
    end else begin
      level_next = ((prev_this << 1) | cmask) & ((prev_low & cur_low) << 1) & prev_low;
    end
  end

  // Level masks: restart on reset or on a new text, otherwise one level per step.
  always_ff @(posedge clk) begin
    if (rst || (cmd.scan_start && in_new_text)) begin
      for (int l = 0; l < LEVELS; l++) begin
        level_masks[l] <= level_init(l);
      end
    end else if (cmd.step_en) begin
      level_masks[cmd.step_lv] <= level_next;
    end
  end

  // Carried low-level masks between steps.
  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      prev_low <= prev_this;
      cur_low  <= level_next;
    end
  end

  // Text position, cleared by a new text and saturating at its maximum.
  assign pos_base = in_new_text ? '0 : text_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
    end else if (cmd.scan_start) begin
      text_position <= (pos_base == POS_MAX) ? pos_base : pos_base + position_t'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      match_end <= MATCH_END_W'(text_position);
    end
  end

  // Status for the controller.
  assign status.last_level = (cmd.step_lv == errs);
  assign status.hit        = (pattern_length != '0) && !cur_low[end_idx];
  assign status.out_busy   = out_valid && !out_ready;

endmodule

/* rtl/core/bitap_k_error_matcher.sv */
// Top level of the bitap k-error approximate string matcher.
//
// Channels: in_ch takes items; action 0 loads one 256-entry character mask
// entry (char_code is the index, mask_value the entry), action 1 scans one
// text byte. new_text restarts the level masks and the text position before
// that byte. out_ch delivers match_end, the text position just after a byte
// that ended a match with at most error_count edits. cfg_ch writes
// error_count (index 0) and pattern_length (index 1); it is always ready.
// Every table entry must be loaded before text is scanned.
// Sequencing: a load item leaves the block ready for the next item. A scan
// item passes a table read, one step per active level through the shared
// level update unit, and a match test; the level loop sets its length. A
// match goes through the output register onto out_ch.
// Reset clears the configuration to error_count 0 and pattern_length 64,
// restarts the level masks and the position; the table keeps its contents.
// A stalled receiver holds the output item; the block still takes the next
// item and only waits if that one produces a match before the output clears.
module bitap_k_error_matcher import bkem_pkg::*; (
  input logic        clk,
  input logic        rst,
  bkem_in_if.sink    in_ch,
  bkem_out_if.source out_ch,
  bkem_cfg_if.sink   cfg_ch
);

  bkem_cmd_t    cmd;
  bkem_status_t status;

  // Sequencing of load and scan items.
  bkem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, level masks, position and output register.
  bkem_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_new_text   (in_ch.new_text),
    .in_char_code  (in_ch.char_code),
    .in_mask_value (in_ch.mask_value),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .cfg_ready     (cfg_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .match_end     (out_ch.match_end),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

/* rtl/core/bkem_checker.sv */
// Port-level assertions for the bitap k-error matcher and their bind.
module bkem_checker import bkem_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_action,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [MATCH_END_W-1:0] match_end
);

  // A scan item keeps the input busy in the cycle after it is taken.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_action) |=> !in_ready)
    else $error("input ready the cycle after a scan item was taken");

  // A load item never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_action && !out_valid) |=> !out_valid)
    else $error("result appeared after a load item");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(match_end)))
    else $error("stalled result dropped or changed");

endmodule

bind bitap_k_error_matcher bkem_checker u_bkem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .match_end (out_ch.match_end)
);

/* sim/bkem_match_checker.sv */
// Checker for the bitap k-error matcher: it predicts every match position and compares.
module bkem_match_checker import bkem_pkg::*; (
  input  logic clk,
  input  logic rst,
  bkem_in_if   in_ch,
  bkem_out_if  out_ch,
  bkem_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  // Own copy of the matcher state and its two registers.
  pat_vec_t               mask_table_copy [TABLE_DEPTH];
  pat_vec_t               level_vecs [LEVELS];
  position_t              text_pos;
  logic [ERR_CFG_W-1:0]   err_reg;
  logic [LEN_CFG_W-1:0]   len_reg;

  // Match positions that are predicted but not yet seen on the output.
  logic [MATCH_END_W-1:0] expected_ends [$];

  int n_fail = 0;

  assign fail_count = n_fail;

  // Print one line per mismatch (up to a limit) and count them all.
  task automatic report_mismatch(input string msg);
    if (n_fail < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $realtime, msg);
    n_fail++;
  endtask

  // A fresh text puts all ones shifted left by the level into each level vector.
  function automatic void restart_levels();
    for (int l = 0; l < LEVELS; l++) level_vecs[l] = PAT_ONES << l;
    text_pos = '0;
  endfunction

  // Advance all active levels by one text byte and queue a match position if the top
  // active level shows a full match. Error counts above the maximum saturate, and so
  // do pattern lengths above the vector width; a length of zero never matches.
  task automatic advance_text(input logic restart, input logic [CODE_W-1:0] code);
    pat_vec_t miss, prev_low, cur_low, prev_this, end_bit;
    int errs, len;
    if (restart) restart_levels();
    errs = (err_reg > MAX_ERRORS) ? MAX_ERRORS : int'(err_reg);
    len  = (len_reg > PATTERN_BITS) ? PATTERN_BITS : int'(len_reg);
    end_bit = (len == 0) ? '0 : (pat_vec_t'(1) << (len - 1));
    miss = ~mask_table_copy[code];
    prev_low = level_vecs[0];
    cur_low = (prev_low << 1) | miss;
    level_vecs[0] = cur_low;
    // Levels above the active error count keep whatever they held before.
    for (int l = 1; l <= errs; l++) begin
      prev_this = level_vecs[l];
      cur_low = ((prev_this << 1) | miss) & ((prev_low & cur_low) << 1) & prev_low;
      level_vecs[l] = cur_low;
      prev_low = prev_this;
    end
    // The position saturates at its largest value.
    if (text_pos != POS_MAX) text_pos = text_pos + 1'b1;
    if ((~cur_low & end_bit) != '0) expected_ends.push_back(MATCH_END_W'(text_pos));
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      err_reg = '0;
      len_reg = LEN_CFG_W'(PATTERN_BITS);
      restart_levels();
      expected_ends.delete();
    end else begin
      // A result is compared with the oldest expected match position.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ends.size() == 0) begin
          report_mismatch($sformatf("match_end %0d with no match expected", out_ch.match_end));
        end else begin
          if (out_ch.match_end !== expected_ends[0])
            report_mismatch($sformatf("match_end %0d, expected %0d",
                                      out_ch.match_end, expected_ends[0]));
          void'(expected_ends.pop_front());
        end
      end

      // Register writes keep only the bits of each register.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_index_t'(cfg_ch.index))
          REG_ERROR_COUNT: begin
            err_reg = cfg_ch.data[ERR_CFG_W-1:0];
          end
          REG_PATTERN_LENGTH: begin
            len_reg = cfg_ch.data[LEN_CFG_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // A load item writes one table entry and ignores new_text; a scan item advances.
      if (in_ch.valid && in_ch.ready) begin
        if (action_t'(in_ch.action) == ACT_LOAD)
          mask_table_copy[in_ch.char_code] = in_ch.mask_value;
        else advance_text(in_ch.new_text, in_ch.char_code);
      end
    end
    outstanding <= expected_ends.size();
  end

endmodule

/* sim/tb_bitap_k_error_matcher.sv */
// Testbench top for the bitap k-error matcher: clock, reset, stimulus, watchdog and verdict.
module tb_bitap_k_error_matcher import bkem_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 800;
  localparam int MATCH_TARGET   = 40;
  localparam int MAX_PHASES     = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [CODE_W-1:0] code_t;
  typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL} edit_kind_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;

  bkem_in_if  in_ch ();
  bkem_out_if out_ch ();
  bkem_cfg_if cfg_ch ();

  bitap_k_error_matcher i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bkem_match_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stimulus bookkeeping: current pattern, its alphabet and what the table holds.
  code_t         pat [$];
  code_t         alph [$];
  pat_vec_t      shadow [TABLE_DEPTH];
  bit            loaded [TABLE_DEPTH];
  bit            tight;
  int            stall_token;
  int            n_scan, n_load, n_match, n_settings;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle stretches: mostly short, some medium and a few long.
  function automatic int idle_len(input bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic pat_vec_t rand_mask();
    return pat_vec_t'({$urandom, $urandom});
  endfunction

  function automatic code_t pick_alpha();
    return alph[$urandom_range(0, alph.size() - 1)];
  endfunction

  // Offer one item after a random gap and wait until it is taken; valid stays high.
  task automatic send_item(input action_t act, input logic nt, input code_t code,
                           input pat_vec_t mask);
    int gap;
    gap = tight ? 0 : idle_len(1'b1);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.new_text   <= nt;
    in_ch.char_code  <= code;
    in_ch.mask_value <= mask;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (act == ACT_SCAN) n_scan++;
    else n_load++;
  endtask

  task automatic load_entry(input code_t code, input pat_vec_t mask, input logic nt);
    send_item(ACT_LOAD, nt, code, mask);
    shadow[code] = mask;
    loaded[code] = 1'b1;
  endtask

  task automatic scan_seq(input code_t txt [$], input logic restart);
    foreach (txt[i]) send_item(ACT_SCAN, restart && (i == 0), txt[i], rand_mask());
  endtask

  // Filler text, mostly from the pattern alphabet, sometimes any byte.
  task automatic scan_filler(input int n);
    code_t b;
    repeat (n) begin
      b = ($urandom_range(0, 9) < 7) ? pick_alpha() : code_t'($urandom_range(0, 255));
      send_item(ACT_SCAN, $urandom_range(0, 19) == 0, b, rand_mask());
    end
  endtask

  // One copy of the pattern with random substitutions, insertions and deletions.
  task automatic scan_copy(input int max_edits, input logic restart);
    code_t q [$];
    int pos;
    q = pat;
    repeat ($urandom_range(0, max_edits)) begin
      pos = $urandom_range(0, q.size() - 1);
      case (edit_kind_t'($urandom_range(0, 2)))
        EDIT_SUB: begin
          q[pos] = pick_alpha();
        end
        EDIT_INS: begin
          q.insert(pos, pick_alpha());
        end
        default: begin
          if (q.size() > 1) q.delete(pos);
        end
      endcase
    end
    scan_seq(q, restart);
  endtask

  // New random pattern over a small alphabet so that matches come often.
  task automatic make_pattern(input int len);
    code_t b;
    int n;
    bit dup;
    alph.delete();
    pat.delete();
    n = $urandom_range(2, 6);
    while (alph.size() < n) begin
      b = code_t'($urandom_range(0, 255));
      dup = 1'b0;
      foreach (alph[i]) if (alph[i] == b) dup = 1'b1;
      if (!dup) alph.push_back(b);
    end
    repeat (len) pat.push_back(pick_alpha());
  endtask

  // Load every table entry that is not yet written or differs from the pattern.
  task automatic install_pattern();
    pat_vec_t want [TABLE_DEPTH];
    foreach (want[c]) want[c] = '0;
    foreach (pat[i]) want[pat[i]][i] = 1'b1;
    for (int c = 0; c < TABLE_DEPTH; c++)
      if (!loaded[c] || shadow[c] != want[c])
        load_entry(code_t'(c), want[c], $urandom_range(0, 1));
  endtask

  // Stop offering items, wait for every expected match and then for the scan latency.
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; spare upper data bits of error_count are random.
  task automatic apply_settings(input int err, input int len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_ERROR_COUNT;
    cfg_ch.data  <= {CFG_DATA_W'($urandom_range(0, 7)) << ERR_CFG_W} | CFG_DATA_W'(err);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.index <= REG_PATTERN_LENGTH;
    cfg_ch.data  <= CFG_DATA_W'(len);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Receiver: random ready with long and short gaps, and a long hold on request.
  initial begin : receiver
    bit level;
    int left, seen;
    level = 1'b0;
    left  = 0;
    seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_token != seen) begin
        seen  = stall_token;
        level = 1'b0;
        left  = LONG_HOLD;
      end else if (left == 0) begin
        level = !level;
        left  = level ? $urandom_range(1, 40) : idle_len(1'b0);
      end else begin
        left--;
      end
      out_ch.ready <= level;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) n_match++;
  end

  // Watchdog: end the run when nothing has been taken on any channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no channel activity for %0d cycles.", WATCHDOG_LIMIT);
    $display("[bitap_k_error_matcher] ERROR");
    $finish;
  end

  // Main stimulus.
  initial begin : stimulus
    code_t txt [$];
    int phase, r, err, plen, lencfg, sat, max_edits;
    bit new_pat, pressure;

    rst <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_SCAN;
    in_ch.new_text   <= 1'b0;
    in_ch.char_code  <= '0;
    in_ch.mask_value <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_ERROR_COUNT;
    cfg_ch.data      <= '0;
    tight = 1'b0;
    stall_token = 0;
    n_scan = 0;
    n_load = 0;
    n_settings = 0;
    foreach (loaded[c]) loaded[c] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a four-byte pattern that uses the lowest and highest byte values.
    apply_settings(0, 4);
    alph = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    pat = alph;
    install_pattern();
    txt = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    scan_seq(txt, 1'b1);
    // A load item that carries new_text must not restart the text.
    load_entry(8'h33, '0, 1'b1);
    scan_seq(txt, 1'b0);

    // One error allowed: substitution, insertion and deletion.
    settle();
    apply_settings(1, 4);
    txt = '{8'h00, 8'hFF, 8'h33, 8'hA5};
    scan_seq(txt, 1'b1);
    txt = '{8'h00, 8'hFF, 8'h33, 8'h5A, 8'hA5};
    scan_seq(txt, 1'b1);
    txt = '{8'h00, 8'h5A, 8'hA5};
    scan_seq(txt, 1'b1);

    // Error count raised in the middle of a text: upper levels keep their old vectors.
    settle();
    apply_settings(MAX_ERRORS, 4);
    txt = '{8'hFF, 8'h5A};
    scan_seq(txt, 1'b0);

    // Error count beyond the maximum together with a pattern length of zero.
    settle();
    apply_settings(15, 0);
    txt = '{8'h00, 8'hFF};
    scan_seq(txt, 1'b1);

    // Pattern length beyond the vector width, and an all-ones table entry.
    settle();
    apply_settings(0, 127);
    load_entry(8'hC3, PAT_ONES, 1'b0);
    txt = '{8'hC3, 8'hC3};
    scan_seq(txt, 1'b1);

    // Random phases: new settings, often a new pattern, then text around pattern copies.
    phase = 0;
    while ((n_scan + n_load < ITEM_TARGET || n_match < MATCH_TARGET) &&
           phase < MAX_PHASES) begin
      settle();
      pressure = (phase == 2);
      if (pressure) begin
        err = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) err = 0;
        else if (r < 20) err = MAX_ERRORS;
        else if (r < 30) err = $urandom_range(MAX_ERRORS + 1, 15);
        else err = $urandom_range(1, 4);
      end

      new_pat = pressure || (phase == 0) || ($urandom_range(0, 9) < 6);
      if (new_pat) begin
        r = $urandom_range(0, 99);
        if (pressure) plen = 3;
        else if (r < 70) plen = $urandom_range(2, 12);
        else if (r < 90) plen = $urandom_range(13, 40);
        else plen = PATTERN_BITS;
        make_pattern(plen);
      end
      plen = pat.size();

      r = $urandom_range(0, 99);
      if (pressure || r < 80) lencfg = plen;
      else if (r < 87) lencfg = 0;
      else if (r < 94) lencfg = $urandom_range(PATTERN_BITS + 1, 127);
      else lencfg = $urandom_range(1, PATTERN_BITS);

      apply_settings(err, lencfg);
      if (new_pat) install_pattern();

      sat = (err > MAX_ERRORS) ? MAX_ERRORS : err;
      max_edits = (sat + 1 > 6) ? 6 : sat + 1;
      tight = pressure || ($urandom_range(0, 9) < 3);

      if (pressure) begin
        // Hold the receiver off while exact copies keep arriving, so the block backs up.
        stall_token++;
        repeat (30) scan_copy(0, 1'b0);
      end else begin
        repeat ($urandom_range(3, 6)) begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            scan_filler($urandom_range(0, 6));
            scan_copy(max_edits, $urandom_range(0, 2) == 0);
          end else if (r < 85) begin
            repeat ($urandom_range(1, 3))
              load_entry(code_t'($urandom_range(0, 255)), rand_mask(), $urandom_range(0, 1));
          end else begin
            scan_filler($urandom_range(5, 20));
          end
        end
      end
      tight = 1'b0;
      phase++;
    end

    settle();
    $display("Run covered %0d text bytes and %0d table loads over %0d register settings;",
             n_scan, n_load, n_settings);
    $display("%0d match positions were checked, %0d mismatches found.", n_match, fail_count);
    if (fail_count == 0) begin
      $display("[bitap_k_error_matcher] OK");
    end else begin
      $display("[bitap_k_error_matcher] ERROR");
    end
    $finish;
  end

endmodule

/* bitap_k_error_matcher.f */
rtl/core/bkem_pkg.sv
rtl/core/bkem_if.sv
rtl/core/bkem_ctrl.sv
rtl/core/bkem_dp.sv
rtl/core/bitap_k_error_matcher.sv
rtl/core/bkem_checker.sv
sim/bkem_match_checker.sv
sim/tb_bitap_k_error_matcher.sv
